@@ hdl/oltf_pkg.sv @@
// Shared definitions for the OLED text frame buffer: geometry, codes,
// controller/datapath interface structs and the 5x7 glyph ROM.
// No dependencies.
package oltf_pkg;

	// Display geometry.
	localparam int DISPLAY_WIDTH  = 128;
	localparam int DISPLAY_HEIGHT = 64;
	localparam int NUM_PAGES      = (DISPLAY_HEIGHT + 7) / 8;
	localparam int WORDS_PER_PAGE = (DISPLAY_WIDTH + 7) / 8;
	localparam int MEM_DEPTH      = NUM_PAGES * WORDS_PER_PAGE;
	localparam int MEM_AW         = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
	localparam int SEND_WORDS     = (WORDS_PER_PAGE > 16) ? 16 : WORDS_PER_PAGE;
	localparam int CNT_W          = (MEM_AW > 5) ? MEM_AW : 5;

	// Glyph cell size and the step count of one cell (columns times two pages).
	localparam int GLYPH_W     = 5;
	localparam int GLYPH_H     = 7;
	localparam int GLYPH_STEPS = 2 * GLYPH_W;

	// Page addressing command bytes.
	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_LOW   = 8'h00;
	localparam logic [7:0] CMD_COL_HIGH  = 8'h10;

	typedef enum logic [2:0] {
		OP_CLEAR  = 3'd0,
		OP_PIXEL  = 3'd1,
		OP_DRAW   = 3'd2,
		OP_STRING = 3'd3,
		OP_UPDATE = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		KIND_CMD  = 2'd0,
		KIND_DATA = 2'd1,
		KIND_DONE = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ASEL_CLEAR = 2'd0,
		ASEL_DRAW  = 2'd1,
		ASEL_WORD  = 2'd2
	} addr_sel_t;

	typedef enum logic [1:0] {
		RSEL_CMD  = 2'd0,
		RSEL_WORD = 2'd1,
		RSEL_DONE = 2'd2
	} res_sel_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      load;
		logic      cnt_clr;
		logic      cnt_inc;
		logic      rd_en;
		logic      wr_en;
		addr_sel_t asel;
		logic      out_load;
		res_sel_t  rsel;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic [2:0] in_op;
		logic       page_ok;
		logic       skip;
		logic       clear_last;
		logic       cmd_last;
		logic       word_last;
		logic       glyph_last;
		logic       mode_pixel;
		logic       out_free;
	} dp_status_t;

	// Glyph ROM: returns five column bytes, column 0 in bits 7:0.
	// Codes outside the ROM draw as a blank cell.
	function automatic logic [39:0] glyph_bits(input logic [7:0] code);
		logic [39:0] g;
		case (code)
			8'h30: g = 40'h3E4549513E;
			8'h31: g = 40'h00407F4200;
			8'h32: g = 40'h4649516142;
			8'h33: g = 40'h3649494122;
			8'h34: g = 40'h107F121418;
			8'h35: g = 40'h3945454527;
			8'h36: g = 40'h3049494A3C;
			8'h37: g = 40'h0305097101;
			8'h38: g = 40'h3649494936;
			8'h39: g = 40'h1E29494906;
			8'h41: g = 40'h7C1211127C;
			8'h42: g = 40'h364949497F;
			8'h43: g = 40'h224141413E;
			8'h44: g = 40'h1C2241417F;
			8'h45: g = 40'h414949497F;
			8'h46: g = 40'h010909097F;
			8'h47: g = 40'h7A4949413E;
			8'h48: g = 40'h7F0808087F;
			8'h49: g = 40'h00417F4100;
			8'h4A: g = 40'h013F414020;
			8'h4B: g = 40'h412214087F;
			8'h4C: g = 40'h404040407F;
			8'h4D: g = 40'h7F0204027F;
			8'h4E: g = 40'h7F0804027F;
			8'h4F: g = 40'h3E4141413E;
			8'h50: g = 40'h060909097F;
			8'h51: g = 40'h5E2151413E;
			8'h52: g = 40'h462919097F;
			8'h53: g = 40'h3149494946;
			8'h54: g = 40'h01017F0101;
			8'h55: g = 40'h3F4040403F;
			8'h56: g = 40'h1F2040201F;
			8'h57: g = 40'h7F2018207F;
			8'h58: g = 40'h6314081463;
			8'h59: g = 40'h0304780403;
			8'h5A: g = 40'h4345495161;
			8'h2E: g = 40'h0000600000;
			8'h2C: g = 40'h0000304000;
			8'h3A: g = 40'h0000360000;
			8'h2D: g = 40'h0808080808;
			8'h2B: g = 40'h08083E0808;
			8'h2F: g = 40'h0106083040;
			8'h25: g = 40'h6304081063;
			8'h21: g = 40'h00005F0000;
			8'h3F: g = 40'h0609510102;
			8'h28: g = 40'h0041221C00;
			8'h29: g = 40'h001C224100;
			default: g = 40'h0000000000;
		endcase
		return g;
	endfunction

endpackage

@@ hdl/oltf_ram.sv @@
// Generic single-port RAM with registered read.
// No dependencies.
module oltf_ram #(
	parameter int DATA_W = 8,
	parameter int DEPTH  = 16,
	parameter int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic              rd_en,
	input  logic [AW-1:0]     addr,
	input  logic [DATA_W-1:0] wr_data,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [DEPTH];

	// Write port and registered read port share one address.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[addr];
		end
	end

endmodule

@@ hdl/oltf_dp.sv @@
// Datapath of the OLED text frame buffer: item registers, string cursor,
// step counter, frame memory with read-modify-write, and result register.
// Depends on oltf_pkg and oltf_ram.
module oltf_dp import oltf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [2:0]  operation,
	input  logic [7:0]  x,
	input  logic [7:0]  y,
	input  logic [7:0]  char_code,
	input  logic        color,
	input  logic        string_start,
	input  logic [2:0]  page,
	input  dp_cmd_t     cmd,
	output dp_status_t  status,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  command_byte,
	output logic [63:0] data_word,
	output logic        last
);

	logic [7:0]        x_q, y_q;
	logic              color_q, mode_pixel_q;
	logic [2:0]        page_q;
	logic [39:0]       glyph_q;
	logic [7:0]        cursor_q;
	logic              stopped_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              out_valid_q;
	logic [1:0]        kind_q;
	logic [7:0]        command_byte_q;
	logic [63:0]       data_word_q;
	logic              last_q;

	logic              in_skip;
	logic [7:0]        origin;
	logic [7:0]        cursor_next;
	logic [2:0]        col;
	logic [7:0]        px;
	logic [4:0]        pg;
	logic [7:0]        y6;
	logic [39:0]       gshift;
	logic [7:0]        gcol;
	logic [7:0]        mask, val;
	logic              draw_ok;
	logic [7:0]        row, rel;
	logic [10:0]       draw_addr_full, word_addr_full;
	logic [MEM_AW-1:0] ram_addr;
	logic [63:0]       lane_mask, lane_val;
	logic [5:0]        lane_sh;
	logic [63:0]       ram_wdata, ram_rdata;
	logic              ram_we;
	logic              out_free;

	// String handling seen at the input: a stopped string drops characters.
	assign in_skip = (operation == OP_STRING) && !string_start && stopped_q;
	assign origin  = (operation == OP_STRING && !string_start) ? cursor_q : x;
	assign cursor_next = origin + 8'd6;

	// Item registers, loaded when the transaction is accepted.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q          <= origin;
			y_q          <= y;
			color_q      <= color;
			page_q       <= page;
			mode_pixel_q <= (operation == OP_PIXEL);
			glyph_q      <= glyph_bits(char_code);
		end
	end

	// String cursor and stop flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q  <= '0;
			stopped_q <= 1'b0;
		end else if (cmd.load && operation == OP_STRING && !in_skip) begin
			cursor_q  <= cursor_next;
			stopped_q <= ({1'b0, cursor_next} + 9'd5) > 9'(DISPLAY_WIDTH);
		end
	end

	// Shared step counter: clear address, command index, word index, glyph step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	// Target column and page of the current drawing step.
	assign col = cnt_q[3:1];
	assign y6  = y_q + 8'd6;
	always_comb begin
		if (mode_pixel_q) begin
			px = x_q;
			pg = y_q[7:3];
		end else begin
			px = x_q + {5'd0, col};
			pg = cnt_q[0] ? y6[7:3] : y_q[7:3];
		end
	end

	assign gshift = glyph_q >> {col, 3'b000};
	assign gcol   = gshift[7:0];

	// Bit mask and new bit values within the target byte.
	always_comb begin
		mask = '0;
		val  = '0;
		row  = '0;
		rel  = '0;
		if (mode_pixel_q) begin
			draw_ok = (x_q < 8'(DISPLAY_WIDTH)) && ({1'b0, y_q} < 9'(DISPLAY_HEIGHT));
			mask    = 8'd1 << y_q[2:0];
			val     = {8{color_q}};
		end else begin
			draw_ok = (px < 8'(DISPLAY_WIDTH)) && ({1'b0, pg} < 6'(NUM_PAGES));
			for (int b = 0; b < 8; b++) begin
				row     = {pg, 3'(b)};
				rel     = row - y_q;
				mask[b] = (rel < 8'(GLYPH_H)) && ({1'b0, row} < 9'(DISPLAY_HEIGHT));
				val[b]  = gcol[rel[2:0]] ? color_q : ~color_q;
			end
		end
	end

	// Memory addresses.
	assign draw_addr_full = 11'(pg) * 11'(WORDS_PER_PAGE) + 11'(px[7:3]);
	assign word_addr_full = 11'(page_q) * 11'(WORDS_PER_PAGE) + 11'(cnt_q);
	always_comb begin
		case (cmd.asel)
			ASEL_CLEAR: ram_addr = cnt_q[MEM_AW-1:0];
			ASEL_DRAW:  ram_addr = draw_addr_full[MEM_AW-1:0];
			default:    ram_addr = word_addr_full[MEM_AW-1:0];
		endcase
	end

	// Merge of the new bits into the stored word.
	assign lane_sh   = {px[2:0], 3'b000};
	assign lane_mask = {56'd0, mask} << lane_sh;
	assign lane_val  = {56'd0, val} << lane_sh;
	always_comb begin
		if (cmd.asel == ASEL_CLEAR) begin
			ram_wdata = '0;
			ram_we    = cmd.wr_en;
		end else begin
			ram_wdata = (ram_rdata & ~lane_mask) | (lane_val & lane_mask);
			ram_we    = cmd.wr_en && draw_ok;
		end
	end

	oltf_ram #(
		.DATA_W(64),
		.DEPTH (MEM_DEPTH)
	) u_frame_ram (
		.clk    (clk),
		.wr_en  (ram_we),
		.rd_en  (cmd.rd_en),
		.addr   (ram_addr),
		.wr_data(ram_wdata),
		.rd_data(ram_rdata)
	);

	// Result register and its valid flag.
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			case (cmd.rsel)
				RSEL_CMD: begin
					kind_q      <= KIND_CMD;
					data_word_q <= '0;
					last_q      <= 1'b0;
					case (cnt_q[1:0])
						2'd0:    command_byte_q <= CMD_PAGE_BASE + {5'd0, page_q};
						2'd1:    command_byte_q <= CMD_COL_LOW;
						default: command_byte_q <= CMD_COL_HIGH;
					endcase
				end
				RSEL_WORD: begin
					kind_q         <= KIND_DATA;
					command_byte_q <= '0;
					data_word_q    <= ram_rdata;
					last_q         <= (cnt_q == CNT_W'(SEND_WORDS - 1));
				end
				default: begin
					kind_q         <= KIND_DONE;
					command_byte_q <= '0;
					data_word_q    <= '0;
					last_q         <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign command_byte = command_byte_q;
	assign data_word    = data_word_q;
	assign last         = last_q;

	// Status toward the controller.
	assign status.in_op      = operation;
	assign status.page_ok    = ({1'b0, page} < 4'(NUM_PAGES));
	assign status.skip       = in_skip;
	assign status.clear_last = (cnt_q == CNT_W'(MEM_DEPTH - 1));
	assign status.cmd_last   = (cnt_q == CNT_W'(2));
	assign status.word_last  = (cnt_q == CNT_W'(SEND_WORDS - 1));
	assign status.glyph_last = (cnt_q == CNT_W'(GLYPH_STEPS - 1));
	assign status.mode_pixel = mode_pixel_q;
	assign status.out_free   = out_free;

endmodule

@@ hdl/oltf_ctrl.sv @@
// Controller state machine of the OLED text frame buffer.
// Sequences memory sweeps, read-modify-write steps and result emission.
// Depends on oltf_pkg.
module oltf_ctrl import oltf_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t status,
	output dp_cmd_t    cmd
);

	typedef enum logic [7:0] {
		S_CLR  = 8'b0000_0001,
		S_IDLE = 8'b0000_0010,
		S_RD   = 8'b0000_0100,
		S_WR   = 8'b0000_1000,
		S_CMD  = 8'b0001_0000,
		S_WRD  = 8'b0010_0000,
		S_WEM  = 8'b0100_0000,
		S_DONE = 8'b1000_0000
	} state_t;

	state_t state_q, state_d;
	logic   busy_q, busy_d;

	// State register; reset starts with a sweep that zeroes the memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			busy_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= busy_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	// Next state and datapath commands.
	always_comb begin
		state_d      = state_q;
		busy_d       = busy_q;
		cmd          = '0;
		cmd.asel     = ASEL_DRAW;
		cmd.rsel     = RSEL_DONE;
		unique case (state_q)
			S_CLR: begin
				cmd.asel    = ASEL_CLEAR;
				cmd.wr_en   = 1'b1;
				cmd.cnt_inc = 1'b1;
				if (status.clear_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = busy_q ? S_DONE : S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.load    = 1'b1;
					cmd.cnt_clr = 1'b1;
					busy_d      = 1'b1;
					case (status.in_op) inside
						OP_CLEAR:          state_d = S_CLR;
						OP_PIXEL, OP_DRAW: state_d = S_RD;
						OP_STRING:         state_d = status.skip ? S_DONE : S_RD;
						OP_UPDATE:         state_d = status.page_ok ? S_CMD : S_DONE;
						default:           state_d = S_DONE;
					endcase
				end
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = S_WR;
			end
			S_WR: begin
				cmd.wr_en = 1'b1;
				if (status.mode_pixel || status.glyph_last) begin
					state_d = S_DONE;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d     = S_RD;
				end
			end
			S_CMD: begin
				cmd.rsel = RSEL_CMD;
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					if (status.cmd_last) begin
						cmd.cnt_clr = 1'b1;
						state_d     = S_WRD;
					end else begin
						cmd.cnt_inc = 1'b1;
					end
				end
			end
			S_WRD: begin
				cmd.asel  = ASEL_WORD;
				cmd.rd_en = 1'b1;
				state_d   = S_WEM;
			end
			S_WEM: begin
				cmd.asel = ASEL_WORD;
				cmd.rsel = RSEL_WORD;
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					if (status.word_last) begin
						busy_d  = 1'b0;
						state_d = S_IDLE;
					end else begin
						cmd.cnt_inc = 1'b1;
						state_d     = S_WRD;
					end
				end
			end
			S_DONE: begin
				cmd.rsel = RSEL_DONE;
				if (status.out_free) begin
					cmd.out_load = 1'b1;
					busy_d       = 1'b0;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

endmodule

@@ hdl/oled_text_framebuffer.sv @@
// Top level of the OLED text frame buffer: page-organized monochrome frame
// memory with 5x7 text drawing and page readout.
// Depends on oltf_pkg, oltf_ctrl and oltf_dp.
//
//   channel  handshake            payload
//   input    in_valid / in_stall  operation, x, y, char_code, color,
//                                 string_start, page
//   output   out_valid/out_stall  kind, command_byte, data_word, last
//
// One item at a time. A glyph takes ten read-modify-write steps of the
// single memory port, clear zeroes one 64-bit word a cycle, and
// update_page sends three command bytes and then 16 data words.
// After reset a sweep over all MEM_DEPTH words (128 at 128x64) zeroes the
// memory while in_stall is high. A stall on the output holds the result
// register; the next item is taken while the final result still waits.
module oled_text_framebuffer import oltf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [7:0]  x,
	input  logic [7:0]  y,
	input  logic [7:0]  char_code,
	input  logic        color,
	input  logic        string_start,
	input  logic [2:0]  page,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  command_byte,
	output logic [63:0] data_word,
	output logic        last
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// Sequencing.
	oltf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.status  (status),
		.cmd     (cmd)
	);

	// Storage and arithmetic.
	oltf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.operation   (operation),
		.x           (x),
		.y           (y),
		.char_code   (char_code),
		.color       (color),
		.string_start(string_start),
		.page        (page),
		.cmd         (cmd),
		.status      (status),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.kind        (kind),
		.command_byte(command_byte),
		.data_word   (data_word),
		.last        (last)
	);

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for oled_text_framebuffer: directed table then random operations,
// every result compared against a behavioral frame memory model.
// Depends on oltf_pkg and the oled_text_framebuffer RTL.
`timescale 1ns / 1ps

module testbench import oltf_pkg::*;;

	localparam int PAGES_USED = (DISPLAY_HEIGHT + 7) / 8;
	localparam int FB_BYTES   = DISPLAY_WIDTH * PAGES_USED;
	localparam int WORDS_SENT = SEND_WORDS;
	localparam int DRAIN_CYCLES = 200;
	localparam int STUCK_LIMIT  = 20000;
	localparam int RANDOM_ITEMS = 440;

	typedef struct {
		logic [2:0] op;
		logic [7:0] px;
		logic [7:0] py;
		logic [7:0] code;
		logic       ink;
		logic       start;
		logic [2:0] pg;
		logic       typed;
		logic [1:0] exp_kind;
		logic       exp_last;
	} stim_row_t;

	typedef struct {
		logic [1:0]  kind;
		logic [7:0]  cmd;
		logic [63:0] data;
		logic        last;
	} result_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [2:0]  operation;
	logic [7:0]  x;
	logic [7:0]  y;
	logic [7:0]  char_code;
	logic        color;
	logic        string_start;
	logic [2:0]  page;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  kind;
	logic [7:0]  command_byte;
	logic [63:0] data_word;
	logic        last;

	// Model state of the frame buffer.
	logic [7:0] shadow_fb [FB_BYTES];
	logic [7:0] shadow_cursor;
	logic       shadow_stopped;

	result_t pending_results[$];
	int      error_count;
	int      result_count;
	int      idle_cycles;
	int      items_sent;
	bit      calm_phase;
	bit      sending_done;

	oled_text_framebuffer uut (
		.clk, .arst_n, .in_valid, .in_stall, .operation, .x, .y, .char_code, .color,
		.string_start, .page, .out_valid, .out_stall, .kind, .command_byte, .data_word, .last
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Glyph column lookup for the model, independent of the RTL ROM.
	function automatic logic [7:0] font_column(input logic [7:0] code, input int col);
		logic [7:0] cols [5];
		case (code)
			"0": cols = '{8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E};
			"1": cols = '{8'h00, 8'h42, 8'h7F, 8'h40, 8'h00};
			"2": cols = '{8'h42, 8'h61, 8'h51, 8'h49, 8'h46};
			"3": cols = '{8'h22, 8'h41, 8'h49, 8'h49, 8'h36};
			"4": cols = '{8'h18, 8'h14, 8'h12, 8'h7F, 8'h10};
			"5": cols = '{8'h27, 8'h45, 8'h45, 8'h45, 8'h39};
			"6": cols = '{8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30};
			"7": cols = '{8'h01, 8'h71, 8'h09, 8'h05, 8'h03};
			"8": cols = '{8'h36, 8'h49, 8'h49, 8'h49, 8'h36};
			"9": cols = '{8'h06, 8'h49, 8'h49, 8'h29, 8'h1E};
			"A": cols = '{8'h7C, 8'h12, 8'h11, 8'h12, 8'h7C};
			"B": cols = '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36};
			"C": cols = '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22};
			"D": cols = '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C};
			"E": cols = '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41};
			"F": cols = '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01};
			"G": cols = '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A};
			"H": cols = '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F};
			"I": cols = '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00};
			"J": cols = '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01};
			"K": cols = '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41};
			"L": cols = '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40};
			"M": cols = '{8'h7F, 8'h02, 8'h04, 8'h02, 8'h7F};
			"N": cols = '{8'h7F, 8'h02, 8'h04, 8'h08, 8'h7F};
			"O": cols = '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E};
			"P": cols = '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06};
			"Q": cols = '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E};
			"R": cols = '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46};
			"S": cols = '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31};
			"T": cols = '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01};
			"U": cols = '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F};
			"V": cols = '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F};
			"W": cols = '{8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F};
			"X": cols = '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63};
			"Y": cols = '{8'h03, 8'h04, 8'h78, 8'h04, 8'h03};
			"Z": cols = '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43};
			".": cols = '{8'h00, 8'h00, 8'h60, 8'h00, 8'h00};
			",": cols = '{8'h00, 8'h40, 8'h30, 8'h00, 8'h00};
			":": cols = '{8'h00, 8'h00, 8'h36, 8'h00, 8'h00};
			"-": cols = '{8'h08, 8'h08, 8'h08, 8'h08, 8'h08};
			"+": cols = '{8'h08, 8'h08, 8'h3E, 8'h08, 8'h08};
			"/": cols = '{8'h40, 8'h30, 8'h08, 8'h06, 8'h01};
			"%": cols = '{8'h63, 8'h10, 8'h08, 8'h04, 8'h63};
			"!": cols = '{8'h00, 8'h00, 8'h5F, 8'h00, 8'h00};
			"?": cols = '{8'h02, 8'h01, 8'h51, 8'h09, 8'h06};
			"(": cols = '{8'h00, 8'h1C, 8'h22, 8'h41, 8'h00};
			")": cols = '{8'h00, 8'h41, 8'h22, 8'h1C, 8'h00};
			default: cols = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
		endcase
		return cols[col];
	endfunction

	task automatic plot_pixel(input int px, input int py, input logic ink);
		int idx;
		if (px < DISPLAY_WIDTH && py < DISPLAY_HEIGHT) begin
			idx = px + (py / 8) * DISPLAY_WIDTH;
			shadow_fb[idx][py % 8] = ink;
		end
	endtask

	// Paint a whole 5x7 cell; clear glyph bits take the opposite color.
	task automatic paint_cell(input logic [7:0] cx, input logic [7:0] cy,
			input logic [7:0] code, input logic ink);
		logic [7:0] colbits;
		logic [7:0] wx;
		logic [7:0] wy;
		for (int c = 0; c < GLYPH_W; c++) begin
			colbits = font_column(code, c);
			wx = cx + 8'(c);
			for (int r = 0; r < GLYPH_H; r++) begin
				wy = cy + 8'(r);
				plot_pixel(wx, wy, colbits[r] ? ink : ~ink);
			end
		end
	endtask

	task automatic push_result(input logic [1:0] k, input logic [7:0] c,
			input logic [63:0] d, input logic l);
		result_t r;
		r.kind = k;
		r.cmd  = c;
		r.data = d;
		r.last = l;
		pending_results.push_back(r);
	endtask

	// Apply one accepted transaction to the model and queue its results.
	task automatic predict_display_op(input stim_row_t s);
		logic [63:0] word;
		int col;
		case (s.op)
			OP_CLEAR:
				foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
			OP_PIXEL:
				plot_pixel(s.px, s.py, s.ink);
			OP_DRAW:
				paint_cell(s.px, s.py, s.code, s.ink);
			OP_STRING: begin
				if (s.start) begin
					shadow_cursor  = s.px;
					shadow_stopped = 1'b0;
				end
				if (!shadow_stopped) begin
					paint_cell(shadow_cursor, s.py, s.code, s.ink);
					shadow_cursor = shadow_cursor + 8'd6;
					if (int'(shadow_cursor) + GLYPH_W > DISPLAY_WIDTH)
						shadow_stopped = 1'b1;
				end
			end
			default: ;
		endcase
		if (s.op == OP_UPDATE && s.pg < PAGES_USED) begin
			push_result(KIND_CMD, CMD_PAGE_BASE + 8'(s.pg), '0, 1'b0);
			push_result(KIND_CMD, CMD_COL_LOW, '0, 1'b0);
			push_result(KIND_CMD, CMD_COL_HIGH, '0, 1'b0);
			for (int w = 0; w < WORDS_SENT; w++) begin
				word = '0;
				for (int b = 0; b < 8; b++) begin
					col = w * 8 + b;
					if (col < DISPLAY_WIDTH)
						word[8 * b +: 8] = shadow_fb[s.pg * DISPLAY_WIDTH + col];
				end
				push_result(KIND_DATA, '0, word, w == WORDS_SENT - 1);
			end
		end else begin
			push_result(KIND_DONE, '0, '0, 1'b1);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		error_count++;
		$display("MISMATCH %s: got %0h expected %0h (result %0d)", what, got, want,
			result_count);
	endtask

	// Result monitor and checker.
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result kind", 64'(kind), '0);
			end else begin
				want = pending_results.pop_front();
				if (kind !== want.kind)
					report_mismatch("kind", 64'(kind), 64'(want.kind));
				if (command_byte !== want.cmd)
					report_mismatch("command_byte", 64'(command_byte), 64'(want.cmd));
				if (data_word !== want.data)
					report_mismatch("data_word", data_word, want.data);
				if (last !== want.last)
					report_mismatch("last", 64'(last), 64'(want.last));
			end
			result_count++;
		end
	end

	// Receiver stalls at random about 7 percent of the time, never during the calm stretch.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= !calm_phase && ($urandom_range(99) < 7);
		end
	end

	// Watchdog on cycles without any accepted transaction.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STUCK_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles", STUCK_LIMIT);
			$display("** oled_text_framebuffer: FAILED **");
			$finish;
		end
	end

	// Present one transaction and hold it until it is accepted. Valid drops
	// only for idle cycles, so transactions can follow back to back.
	task automatic send_display_op(input stim_row_t s);
		while (!calm_phase && $urandom_range(99) < 7) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= s.op;
		x            <= s.px;
		y            <= s.py;
		char_code    <= s.code;
		color        <= s.ink;
		string_start <= s.start;
		page         <= s.pg;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_display_op(s);
		items_sent++;
	endtask

	function automatic stim_row_t make_row(input logic [2:0] op, input logic [7:0] px,
			input logic [7:0] py, input logic [7:0] code, input logic ink,
			input logic start, input logic [2:0] pg);
		stim_row_t s;
		s.op = op; s.px = px; s.py = py; s.code = code;
		s.ink = ink; s.start = start; s.pg = pg;
		s.typed = 1'b0; s.exp_kind = KIND_DONE; s.exp_last = 1'b1;
		return s;
	endfunction

	// Random transaction: mostly well-formed strings and glyphs near the screen.
	function automatic stim_row_t random_row(input int n);
		stim_row_t s;
		logic [7:0] codes [8] = '{"A", "Z", "0", "9", "?", "(", 8'h61, 8'h00};
		int pick;
		s = make_row(3'($urandom_range(7)), 8'($urandom), 8'($urandom), 8'($urandom),
			1'($urandom), 1'($urandom), 3'($urandom));
		pick = $urandom_range(99);
		if (pick < 35) begin
			s.op    = OP_STRING;
			s.start = ($urandom_range(9) == 0);
			s.px    = 8'($urandom_range(DISPLAY_WIDTH - 1));
			s.py    = 8'($urandom_range(DISPLAY_HEIGHT - 1));
			if ($urandom_range(1)) s.code = codes[$urandom_range(7)];
		end else if (pick < 55) begin
			s.op = OP_DRAW;
			if ($urandom_range(3) != 0) begin
				s.px = 8'($urandom_range(DISPLAY_WIDTH - 1));
				s.py = 8'($urandom_range(DISPLAY_HEIGHT - 1));
			end
			if ($urandom_range(1)) s.code = 8'($urandom_range(8'h20, 8'h5A));
		end else if (pick < 70) begin
			s.op = OP_PIXEL;
			if ($urandom_range(3) != 0) begin
				s.px = 8'($urandom_range(DISPLAY_WIDTH - 1));
				s.py = 8'($urandom_range(DISPLAY_HEIGHT - 1));
			end
		end else if (pick < 90) begin
			s.op = OP_UPDATE;
		end else if (pick < 92) begin
			s.op = OP_CLEAR;
		end
		return s;
	endfunction

	// Stimulus: directed table, then random transactions.
	initial begin
		stim_row_t directed [$];
		stim_row_t s;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = '0; x = '0; y = '0; char_code = '0;
		color = 1'b0; string_start = 1'b0; page = '0;
		error_count = 0; result_count = 0; items_sent = 0;
		calm_phase = 1'b0; sending_done = 1'b0;
		foreach (shadow_fb[i]) shadow_fb[i] = 8'h00;
		shadow_cursor = '0;
		shadow_stopped = 1'b0;

		directed.push_back(make_row(OP_UPDATE, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_row(OP_UPDATE, 0, 0, 0, 0, 0, 7));
		directed.push_back(make_row(OP_PIXEL, 0, 0, 0, 1, 0, 0));
		directed.push_back(make_row(OP_PIXEL, DISPLAY_WIDTH - 1, DISPLAY_HEIGHT - 1,
			0, 1, 0, 0));
		// Pixels off the display leave memory untouched.
		directed.push_back(make_row(OP_PIXEL, 8'hFF, 8'h00, 0, 1, 0, 0));
		directed.push_back(make_row(OP_PIXEL, 8'h00, 8'hFF, 0, 1, 0, 0));
		directed.push_back(make_row(OP_DRAW, 2, 3, "A", 1, 0, 0));
		directed.push_back(make_row(OP_DRAW, 20, 5, "?", 0, 0, 0));
		// Unknown codes draw a blank cell.
		directed.push_back(make_row(OP_DRAW, 30, 9, 8'h61, 1, 0, 0));
		directed.push_back(make_row(OP_DRAW, 40, 12, 8'hFF, 1, 0, 0));
		// A cell starting near 255 wraps back onto the left edge and top rows.
		directed.push_back(make_row(OP_DRAW, 8'hFE, 8'hFD, "W", 1, 0, 0));
		directed.push_back(make_row(OP_STRING, 110, 40, "H", 1, 1, 0));
		directed.push_back(make_row(OP_STRING, 0, 40, "I", 1, 0, 0));
		directed.push_back(make_row(OP_STRING, 0, 40, "!", 1, 0, 0));
		directed.push_back(make_row(OP_STRING, 0, 40, "X", 1, 0, 0));
		directed.push_back(make_row(OP_UPDATE, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_row(OP_UPDATE, 0, 0, 0, 0, 0, 1));
		directed.push_back(make_row(OP_UPDATE, 0, 0, 0, 0, 0, 5));
		directed.push_back(make_row(3'd5, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_row(3'd7, 8'hFF, 8'hFF, 8'hFF, 1, 1, 7));
		directed.push_back(make_row(OP_CLEAR, 0, 0, 0, 0, 0, 0));
		directed.push_back(make_row(OP_UPDATE, 0, 0, 0, 0, 0, 7));
		// Done-only rows: the expected result is known without the model.
		foreach (directed[i])
			if (directed[i].op != OP_UPDATE || directed[i].pg >= PAGES_USED)
				directed[i].typed = 1'b1;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].typed) begin
				send_display_op(directed[i]);
				if (pending_results[$].kind !== directed[i].exp_kind ||
						pending_results[$].last !== directed[i].exp_last)
					report_mismatch("typed done row", 64'(pending_results[$].kind),
						64'(directed[i].exp_kind));
			end else begin
				send_display_op(directed[i]);
			end
		end

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm_phase = (n >= 150 && n < 210);
			s = random_row(n);
			send_display_op(s);
		end
		in_valid <= 1'b0;
		calm_phase = 1'b0;
		sending_done = 1'b1;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d operations (clear, pixel, glyph, string, page readout);", items_sent);
		$display("checked %0d results against the frame memory model.", result_count);
		if (error_count == 0)
			$display("** oled_text_framebuffer: PASSED **");
		else
			$display("** oled_text_framebuffer: FAILED **");
		$finish;
	end

endmodule
